/* design/dmc_pkg.sv */
`default_nettype none

package dmc_pkg;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_CARVE = 2'd1;
	localparam logic [1:0] ACT_BACK  = 2'd2;
	localparam logic [1:0] ACT_IDLE  = 2'd3;

	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_EAST  = 2'd1;
	localparam logic [1:0] DIR_SOUTH = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic CFG_GRID_COLS = 1'b0;
	localparam logic CFG_GRID_ROWS = 1'b1;

	localparam logic [6:0] GRID_RESET = 7'd64;

	localparam logic [4:0] CELL_SEEN    = 5'b00001;
	localparam logic [4:0] CELL_NORTH   = 5'b00010;
	localparam logic [4:0] CELL_EAST    = 5'b00100;
	localparam logic [4:0] CELL_SOUTH   = 5'b01000;
	localparam logic [4:0] CELL_WEST    = 5'b10000;

	typedef struct packed {
		logic [6:0]  rows;
		logic [6:0]  cols;
		logic [13:0] total;
	} dmc_grid_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
		logic rd;
	} dmc_stk_cmd_t;

	function automatic logic [4:0] own_wall(input logic [1:0] dir);
		unique case (dir)
			DIR_NORTH: own_wall = CELL_NORTH;
			DIR_EAST:  own_wall = CELL_EAST;
			DIR_SOUTH: own_wall = CELL_SOUTH;
			DIR_WEST:  own_wall = CELL_WEST;
			default:   own_wall = CELL_NORTH;
		endcase
	endfunction

	function automatic logic [4:0] far_wall(input logic [1:0] dir);
		unique case (dir)
			DIR_NORTH: far_wall = CELL_SOUTH;
			DIR_EAST:  far_wall = CELL_WEST;
			DIR_SOUTH: far_wall = CELL_NORTH;
			DIR_WEST:  far_wall = CELL_EAST;
			default:   far_wall = CELL_SOUTH;
		endcase
	endfunction

endpackage

`default_nettype wire

/* design/dmc_stack.sv */
`default_nettype none

module dmc_stack #(
	parameter int DEPTH = 4096,
	parameter int EW = 12,
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dmc_pkg::dmc_stk_cmd_t cmd,
	input  wire logic [EW-1:0]         push_data,
	output logic [EW-1:0]              rd_data,
	output logic [LW-1:0]              level
);

	localparam int IW = $clog2(DEPTH);

	logic [EW-1:0] mem [DEPTH];
	logic [LW-1:0] level_q;
	logic [LW-1:0] top_lvl;
	logic [EW-1:0] rd_data_q;
	logic          push_ok;

	assign top_lvl = level_q - LW'(1);
	assign push_ok = cmd.push && (level_q < LW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else begin
			priority if (cmd.clear) begin
				level_q <= '0;
			end else if (push_ok) begin
				level_q <= level_q + LW'(1);
			end else if (cmd.pop) begin
				level_q <= top_lvl;
			end else begin
				level_q <= level_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[level_q[IW-1:0]] <= push_data;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[top_lvl[IW-1:0]];
		end
	end

	assign rd_data = rd_data_q;
	assign level   = level_q;

endmodule

`default_nettype wire

/* design/dmc_pick.sv */
`default_nettype none

module dmc_pick (
	input  wire logic [3:0]  open_mask,
	input  wire logic [15:0] random_value,
	output logic [1:0]       dir
);

	import dmc_pkg::*;

	logic [2:0] count;
	logic [5:0] nib_sum;
	logic [3:0] pair_sum;
	logic [1:0] mod3;
	logic [1:0] k;
	logic [2:0] seen;

	always_comb begin
		count = 3'(open_mask[0]) + 3'(open_mask[1]) + 3'(open_mask[2]) + 3'(open_mask[3]);

		// Sixteen and four are both one modulo three, so digit sums keep the residue.
		nib_sum = 6'(random_value[3:0]) + 6'(random_value[7:4])
			+ 6'(random_value[11:8]) + 6'(random_value[15:12]);
		pair_sum = 4'(nib_sum[1:0]) + 4'(nib_sum[3:2]) + 4'(nib_sum[5:4]);
		priority if (pair_sum >= 4'd6) begin
			mod3 = 2'(pair_sum - 4'd6);
		end else if (pair_sum >= 4'd3) begin
			mod3 = 2'(pair_sum - 4'd3);
		end else begin
			mod3 = pair_sum[1:0];
		end

		unique case (count)
			3'd2:    k = {1'b0, random_value[0]};
			3'd3:    k = mod3;
			3'd4:    k = random_value[1:0];
			default: k = 2'd0;
		endcase

		dir  = DIR_NORTH;
		seen = 3'd0;
		for (int d = 0; d < 4; d++) begin
			if (open_mask[d]) begin
				if (seen == {1'b0, k}) begin
					dir = 2'(d);
				end
				seen = seen + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/dmc_ctrl.sv */
`default_nettype none

module dmc_ctrl #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	localparam int RW = $clog2(MAX_ROWS),
	localparam int CW = $clog2(MAX_COLS),
	localparam int LW = $clog2(MAX_ROWS * MAX_COLS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dmc_pkg::dmc_grid_t    grid,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  operation,
	input  wire logic [5:0]            start_row,
	input  wire logic [5:0]            start_col,
	input  wire logic [15:0]           random_value,
	output dmc_pkg::dmc_stk_cmd_t      stk_cmd,
	output logic [RW+CW-1:0]           stk_push_data,
	input  wire logic [RW+CW-1:0]      stk_rd_data,
	input  wire logic [LW-1:0]         stk_level,
	output logic [3:0]                 pick_open,
	output logic [15:0]                pick_random,
	input  wire logic [1:0]            pick_dir,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 action,
	output logic [5:0]                 from_row,
	output logic [5:0]                 from_col,
	output logic [1:0]                 direction,
	output logic [5:0]                 to_row,
	output logic [5:0]                 to_col,
	output logic [12:0]                cells_visited,
	output logic                       done_res
);

	import dmc_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW = $clog2(CELLS);
	localparam int CMPW = (LW > 14) ? LW : 14;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_CLEAR    = 11'b000_0000_0010,
		S_MARK     = 11'b000_0000_0100,
		S_TOP      = 11'b000_0000_1000,
		S_NBR      = 11'b000_0001_0000,
		S_PICK     = 11'b000_0010_0000,
		S_WR_OWN   = 11'b000_0100_0000,
		S_WR_NBR   = 11'b000_1000_0000,
		S_POP      = 11'b001_0000_0000,
		S_POP_WAIT = 11'b010_0000_0000,
		S_RES      = 11'b100_0000_0000
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
		cell_addr = AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
	endfunction

	state_t        state_q;
	logic [RW-1:0] cur_r_q;
	logic [CW-1:0] cur_c_q;
	logic [RW-1:0] to_r_q;
	logic [CW-1:0] to_c_q;
	logic [1:0]    act_q;
	logic [1:0]    dir_q;
	logic [15:0]   rnd_q;
	logic [2:0]    idx_q;
	logic [4:0]    own_q;
	logic [3:0]    open_q;
	logic [LW-1:0] visit_q;
	logic          running_q;
	logic [AW-1:0] clr_q;

	logic          out_valid_q;
	logic [1:0]    out_action_q;
	logic [5:0]    out_from_r_q;
	logic [5:0]    out_from_c_q;
	logic [1:0]    out_dir_q;
	logic [5:0]    out_to_r_q;
	logic [5:0]    out_to_c_q;
	logic [12:0]   out_visit_q;
	logic          out_done_q;

	logic [4:0]    cell_mem [CELLS];
	logic          cm_we;
	logic [AW-1:0] cm_waddr;
	logic [4:0]    cm_wdata;
	logic          cm_re;
	logic [AW-1:0] cm_raddr;
	logic [4:0]    cm_rdata_q;

	logic [8:0]    rows9;
	logic [8:0]    cols9;
	logic [8:0]    r9;
	logic [8:0]    c9;
	logic [3:0]    in_grid;
	logic [RW-1:0] nb_r [4];
	logic [CW-1:0] nb_c [4];
	logic [1:0]    rd_dir;
	logic [1:0]    cap_dir;
	logic [6:0]    sr7;
	logic [6:0]    sc7;
	logic [6:0]    r_cl7;
	logic [6:0]    c_cl7;
	logic          all_visited;
	logic          accept;
	logic          res_load;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign res_load    = (state_q == S_RES) && (!out_valid_q || out_ready);
	assign all_visited = CMPW'(visit_q) >= CMPW'(grid.total);
	assign pick_open   = open_q;
	assign pick_random = rnd_q;
	assign rd_dir      = 2'(idx_q - 3'd1);
	assign cap_dir     = 2'(idx_q - 3'd2);

	always_comb begin
		rows9 = 9'(grid.rows);
		cols9 = 9'(grid.cols);
		r9    = 9'(cur_r_q);
		c9    = 9'(cur_c_q);
		in_grid[0] = (r9 != 9'd0) && ((r9 - 9'd1) < rows9) && (c9 < cols9);
		in_grid[1] = (r9 < rows9) && ((c9 + 9'd1) < cols9);
		in_grid[2] = ((r9 + 9'd1) < rows9) && (c9 < cols9);
		in_grid[3] = (c9 != 9'd0) && (r9 < rows9) && ((c9 - 9'd1) < cols9);
		nb_r[0] = cur_r_q - RW'(1);
		nb_c[0] = cur_c_q;
		nb_r[1] = cur_r_q;
		nb_c[1] = cur_c_q + CW'(1);
		nb_r[2] = cur_r_q + RW'(1);
		nb_c[2] = cur_c_q;
		nb_r[3] = cur_r_q;
		nb_c[3] = cur_c_q - CW'(1);

		sr7   = {1'b0, start_row};
		sc7   = {1'b0, start_col};
		r_cl7 = (sr7 > grid.rows - 7'd1) ? grid.rows - 7'd1 : sr7;
		c_cl7 = (sc7 > grid.cols - 7'd1) ? grid.cols - 7'd1 : sc7;
	end

	always_comb begin
		cm_we         = 1'b0;
		cm_waddr      = cell_addr(cur_r_q, cur_c_q);
		cm_wdata      = '0;
		cm_re         = 1'b0;
		cm_raddr      = cell_addr(cur_r_q, cur_c_q);
		stk_cmd       = '0;
		stk_push_data = {cur_r_q, cur_c_q};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (operation == OP_START) begin
						stk_cmd.clear = 1'b1;
					end else if (running_q && (stk_level != '0)) begin
						stk_cmd.rd = 1'b1;
					end
				end
			end
			S_CLEAR: begin
				cm_we    = 1'b1;
				cm_waddr = clr_q;
			end
			S_MARK: begin
				cm_we        = 1'b1;
				cm_wdata     = CELL_SEEN;
				stk_cmd.push = 1'b1;
			end
			S_NBR: begin
				if (idx_q == 3'd0) begin
					cm_re = 1'b1;
				end else if (idx_q <= 3'd4) begin
					cm_re    = in_grid[rd_dir];
					cm_raddr = cell_addr(nb_r[rd_dir], nb_c[rd_dir]);
				end
			end
			S_PICK: begin
				stk_cmd.pop = (open_q == 4'd0);
			end
			S_WR_OWN: begin
				cm_we    = 1'b1;
				cm_wdata = own_q | own_wall(dir_q);
			end
			S_WR_NBR: begin
				cm_we         = 1'b1;
				cm_waddr      = cell_addr(nb_r[dir_q], nb_c[dir_q]);
				cm_wdata      = far_wall(dir_q) | CELL_SEEN;
				stk_cmd.push  = 1'b1;
				stk_push_data = {nb_r[dir_q], nb_c[dir_q]};
			end
			S_POP: begin
				stk_cmd.rd = (stk_level != '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cell_mem[cm_waddr] <= cm_wdata;
		end
		if (cm_re) begin
			cm_rdata_q <= cell_mem[cm_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			visit_q   <= '0;
			running_q <= 1'b0;
			idx_q     <= '0;
			clr_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (operation == OP_START) begin
							clr_q   <= '0;
							state_q <= S_CLEAR;
						end else if (running_q && (stk_level != '0)) begin
							state_q <= S_TOP;
						end else begin
							state_q <= S_RES;
						end
					end
				end
				S_CLEAR: begin
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= S_MARK;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_MARK: begin
					visit_q   <= LW'(1);
					running_q <= 1'b1;
					state_q   <= S_RES;
				end
				S_TOP: begin
					idx_q   <= '0;
					state_q <= all_visited ? S_RES : S_NBR;
				end
				S_NBR: begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd5) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					state_q <= (open_q == 4'd0) ? S_POP : S_WR_OWN;
				end
				S_WR_OWN: begin
					state_q <= S_WR_NBR;
				end
				S_WR_NBR: begin
					visit_q <= visit_q + LW'(1);
					state_q <= S_RES;
				end
				S_POP: begin
					state_q <= (stk_level != '0) ? S_POP_WAIT : S_RES;
				end
				S_POP_WAIT: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					dir_q <= DIR_NORTH;
					rnd_q <= random_value;
					if (operation == OP_START) begin
						cur_r_q <= RW'(r_cl7);
						cur_c_q <= CW'(c_cl7);
						to_r_q  <= RW'(r_cl7);
						to_c_q  <= CW'(c_cl7);
						act_q   <= ACT_START;
					end else begin
						cur_r_q <= '0;
						cur_c_q <= '0;
						to_r_q  <= '0;
						to_c_q  <= '0;
						act_q   <= ACT_IDLE;
					end
				end
			end
			S_TOP: begin
				cur_r_q <= stk_rd_data[RW+CW-1:CW];
				cur_c_q <= stk_rd_data[CW-1:0];
				to_r_q  <= stk_rd_data[RW+CW-1:CW];
				to_c_q  <= stk_rd_data[CW-1:0];
				act_q   <= ACT_IDLE;
			end
			S_NBR: begin
				if (idx_q == 3'd1) begin
					own_q <= cm_rdata_q;
				end else if (idx_q >= 3'd2) begin
					open_q[cap_dir] <= in_grid[cap_dir] && !cm_rdata_q[0];
				end
			end
			S_PICK: begin
				if (open_q == 4'd0) begin
					act_q <= ACT_BACK;
				end else begin
					dir_q <= pick_dir;
				end
			end
			S_WR_NBR: begin
				act_q  <= ACT_CARVE;
				to_r_q <= nb_r[dir_q];
				to_c_q <= nb_c[dir_q];
			end
			S_POP: begin
				to_r_q <= '0;
				to_c_q <= '0;
			end
			S_POP_WAIT: begin
				to_r_q <= stk_rd_data[RW+CW-1:CW];
				to_c_q <= stk_rd_data[CW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_action_q <= act_q;
			out_from_r_q <= 6'(cur_r_q);
			out_from_c_q <= 6'(cur_c_q);
			out_dir_q    <= dir_q;
			out_to_r_q   <= 6'(to_r_q);
			out_to_c_q   <= 6'(to_c_q);
			out_visit_q  <= 13'(visit_q);
			out_done_q   <= running_q && all_visited;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = out_action_q;
	assign from_row      = out_from_r_q;
	assign from_col      = out_from_c_q;
	assign direction     = out_dir_q;
	assign to_row        = out_to_r_q;
	assign to_col        = out_to_c_q;
	assign cells_visited = out_visit_q;
	assign done_res      = out_done_q;

endmodule

`default_nettype wire

/* design/dfs_maze_carver.sv */
`default_nettype none

// Depth-first maze carver. Cell walls and visited marks live in one synchronous
// memory of MAX_ROWS*MAX_COLS entries and the path in a second one of the same depth.
// Items are worked one at a time, and a finished result waits in an output register
// while the next item is taken. A carve or backtrack step reads the stack top, reads
// the own and neighbor cells in turn through the single cell memory port and captures
// the last read, picks a direction, then either writes back the own and the neighbor
// cell or pops and rereads the new top, and finally loads the result. A backtrack that
// empties the path skips the reread. A start sweeps the whole cell memory, one entry a
// cycle, before it marks the start cell. A step before any start or on an empty path
// goes straight to loading its result, and a step on a finished maze reads the stack
// top first. Any item waits longer while the output register still holds a result
// that has not been taken.
module dfs_maze_carver #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [5:0]  start_row,
	input  wire logic [5:0]  start_col,
	input  wire logic [15:0] random_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       action,
	output logic [5:0]       from_row,
	output logic [5:0]       from_col,
	output logic [1:0]       direction,
	output logic [5:0]       to_row,
	output logic [5:0]       to_col,
	output logic [12:0]      cells_visited,
	output logic             done_res
);

	import dmc_pkg::*;

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int LW = $clog2(CELLS + 1);

	function automatic logic [6:0] clamp_dim(input logic [6:0] v, input logic [8:0] cap);
		priority if (v == 7'd0) begin
			clamp_dim = 7'd1;
		end else if ({2'b00, v} > cap) begin
			clamp_dim = cap[6:0];
		end else begin
			clamp_dim = v;
		end
	endfunction

	logic [6:0]    grid_cols_q;
	logic [6:0]    grid_rows_q;
	dmc_grid_t     grid;
	dmc_stk_cmd_t  stk_cmd;
	logic [RW+CW-1:0] stk_push_data;
	logic [RW+CW-1:0] stk_rd_data;
	logic [LW-1:0] stk_level;
	logic [3:0]    pick_open;
	logic [15:0]   pick_random;
	logic [1:0]    pick_dir;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= GRID_RESET;
			grid_rows_q <= GRID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GRID_COLS: grid_cols_q <= cfg_data;
				CFG_GRID_ROWS: grid_rows_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		grid.rows  = clamp_dim(grid_rows_q, 9'(MAX_ROWS));
		grid.cols  = clamp_dim(grid_cols_q, 9'(MAX_COLS));
		grid.total = 14'(grid.rows) * 14'(grid.cols);
	end

	dmc_stack #(
		.DEPTH (CELLS),
		.EW    (RW + CW)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (stk_cmd),
		.push_data (stk_push_data),
		.rd_data   (stk_rd_data),
		.level     (stk_level)
	);

	dmc_pick u_pick (
		.open_mask    (pick_open),
		.random_value (pick_random),
		.dir          (pick_dir)
	);

	dmc_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.grid          (grid),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.start_row     (start_row),
		.start_col     (start_col),
		.random_value  (random_value),
		.stk_cmd       (stk_cmd),
		.stk_push_data (stk_push_data),
		.stk_rd_data   (stk_rd_data),
		.stk_level     (stk_level),
		.pick_open     (pick_open),
		.pick_random   (pick_random),
		.pick_dir      (pick_dir),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.from_row      (from_row),
		.from_col      (from_col),
		.direction     (direction),
		.to_row        (to_row),
		.to_col        (to_col),
		.cells_visited (cells_visited),
		.done_res      (done_res)
	);

endmodule

`default_nettype wire

/* design/dmc_checker.sv */
`default_nettype none

module dmc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  action,
	input wire logic [5:0]  from_row,
	input wire logic [5:0]  from_col,
	input wire logic [1:0]  direction,
	input wire logic [5:0]  to_row,
	input wire logic [5:0]  to_col,
	input wire logic [12:0] cells_visited
);

	import dmc_pkg::*;

	a_start_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_START)
		|-> (cells_visited == 13'd1) && (from_row == to_row) && (from_col == to_col))
		else $error("start item does not report one visited cell at a single position");

	a_dir_only_carve: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != ACT_CARVE) |-> (direction == DIR_NORTH))
		else $error("direction is set on an item that carved nothing");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accepted item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(cells_visited))
		else $error("stalled result changed or vanished");

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (.*);

`default_nettype wire

/* dv/tb_dfs_maze_carver.sv */
`timescale 1ns / 100ps

module tb_dfs_maze_carver;
	import dmc_pkg::*;

	localparam int ROWS_MAX = 64;
	localparam int COLS_MAX = 64;
	localparam int CELL_COUNT = ROWS_MAX * COLS_MAX;
	localparam int ITEM_GOAL = 1400;
	localparam int QUIET_LIMIT = 40000;

	typedef struct packed {
		logic        op;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [15:0] rand_val;
	} carve_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [5:0]  from_row;
		logic [5:0]  from_col;
		logic [1:0]  direction;
		logic [5:0]  to_row;
		logic [5:0]  to_col;
		logic [12:0] cells_visited;
		logic        done_res;
	} move_t;

	typedef struct {
		bit          is_grid;
		logic [6:0]  grid_cols;
		logic [6:0]  grid_rows;
		carve_item_t item;
		bit          typed;
		move_t       want;
	} drill_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_GRID_COLS;
	logic [6:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = OP_STEP;
	logic [5:0]  start_row = '0;
	logic [5:0]  start_col = '0;
	logic [15:0] random_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  action;
	logic [5:0]  from_row;
	logic [5:0]  from_col;
	logic [1:0]  direction;
	logic [5:0]  to_row;
	logic [5:0]  to_col;
	logic [12:0] cells_visited;
	logic        done_res;

	logic [4:0]  maze_cells [CELL_COUNT];
	logic [11:0] trail [CELL_COUNT];
	int          trail_depth;
	int          visited_count;
	bit          carving;
	logic [6:0]  cols_cfg;
	logic [6:0]  rows_cfg;

	move_t       moves_due [$];
	drill_t      drill [$];
	int          failures = 0;
	int          items_sent = 0;
	int          grids_used = 0;
	int          quiet_cycles = 0;
	int          action_seen [4] = '{0, 0, 0, 0};
	bit          no_gaps = 1'b0;

	dfs_maze_carver #(
		.MAX_ROWS(ROWS_MAX),
		.MAX_COLS(COLS_MAX)
	) dut (.*);

	always #5 clk = ~clk;

	function automatic int span(logic [6:0] v, int top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return int'(v);
	endfunction

	function automatic move_t carve_next(carve_item_t it);
		move_t m;
		int rows, cols, r, c, nr, nc, n, d, pick;
		int dirs [4];
		int dr [4] = '{-1, 0, 1, 0};
		int dc [4] = '{0, 1, 0, -1};
		logic [4:0] near_side [4] = '{CELL_NORTH, CELL_EAST, CELL_SOUTH, CELL_WEST};
		logic [4:0] far_side [4] = '{CELL_SOUTH, CELL_WEST, CELL_NORTH, CELL_EAST};
		rows = span(rows_cfg, ROWS_MAX);
		cols = span(cols_cfg, COLS_MAX);
		m = '0;
		m.action = ACT_IDLE;
		if (it.op == OP_START) begin
			r = (it.row > rows - 1) ? rows - 1 : it.row;
			c = (it.col > cols - 1) ? cols - 1 : it.col;
			foreach (maze_cells[i])
				maze_cells[i] = '0;
			trail[0] = {r[5:0], c[5:0]};
			trail_depth = 1;
			maze_cells[r * COLS_MAX + c] = CELL_SEEN;
			visited_count = 1;
			carving = 1'b1;
			m.action = ACT_START;
			m.from_row = 6'(r);
			m.from_col = 6'(c);
			m.to_row = 6'(r);
			m.to_col = 6'(c);
		end else if (carving && trail_depth > 0) begin
			r = int'(trail[trail_depth - 1][11:6]);
			c = int'(trail[trail_depth - 1][5:0]);
			m.from_row = 6'(r);
			m.from_col = 6'(c);
			m.to_row = 6'(r);
			m.to_col = 6'(c);
			if (visited_count < rows * cols) begin
				n = 0;
				for (d = 0; d < 4; d++) begin
					nr = r + dr[d];
					nc = c + dc[d];
					if (nr >= 0 && nc >= 0 && nr < rows && nc < cols &&
					    !maze_cells[nr * COLS_MAX + nc][0]) begin
						dirs[n] = d;
						n++;
					end
				end
				if (n > 0) begin
					pick = dirs[int'(it.rand_val) % n];
					nr = r + dr[pick];
					nc = c + dc[pick];
					maze_cells[r * COLS_MAX + c] |= near_side[pick];
					maze_cells[nr * COLS_MAX + nc] |= far_side[pick] | CELL_SEEN;
					if (trail_depth < CELL_COUNT) begin
						trail[trail_depth] = {nr[5:0], nc[5:0]};
						trail_depth++;
					end
					visited_count++;
					m.action = ACT_CARVE;
					m.direction = pick[1:0];
					m.to_row = 6'(nr);
					m.to_col = 6'(nc);
				end else begin
					trail_depth--;
					m.action = ACT_BACK;
					m.to_row = (trail_depth > 0) ? trail[trail_depth - 1][11:6] : 6'd0;
					m.to_col = (trail_depth > 0) ? trail[trail_depth - 1][5:0] : 6'd0;
				end
			end
		end
		m.cells_visited = 13'(visited_count);
		m.done_res = carving && visited_count >= rows * cols;
		return m;
	endfunction

	function automatic move_t mv(logic [1:0] act, int fr, int fc, logic [1:0] dir,
				     int tr, int tc, int vis, logic done);
		move_t m;
		m.action = act;
		m.from_row = 6'(fr);
		m.from_col = 6'(fc);
		m.direction = dir;
		m.to_row = 6'(tr);
		m.to_col = 6'(tc);
		m.cells_visited = 13'(vis);
		m.done_res = done;
		return m;
	endfunction

	function automatic drill_t grid_row(int cols, int rows);
		drill_t row;
		row = '{default: '0};
		row.is_grid = 1'b1;
		row.grid_cols = 7'(cols);
		row.grid_rows = 7'(rows);
		return row;
	endfunction

	function automatic drill_t item_row(logic op, int r, int c, int rv, bit typed,
					    move_t want);
		drill_t row;
		row = '{default: '0};
		row.item = {op, 6'(r), 6'(c), 16'(rv)};
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	task automatic match_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	task automatic offer_item(carve_item_t it, bit typed, move_t want);
		move_t m;
		no_gaps = items_sent >= 600 && items_sent < 850;
		while (!no_gaps && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.op;
		start_row <= it.row;
		start_col <= it.col;
		random_value <= it.rand_val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		m = carve_next(it);
		moves_due = {moves_due, (typed ? want : m)};
		items_sent++;
	endtask

	task automatic offer_random(bit is_start);
		carve_item_t it;
		it.op = is_start ? OP_START : OP_STEP;
		it.row = 6'($urandom_range(0, 63));
		it.col = 6'($urandom_range(0, 63));
		it.rand_val = 16'($urandom_range(0, 65535));
		offer_item(it, 1'b0, '0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (moves_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_grid(logic [6:0] cols, logic [6:0] rows);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_GRID_COLS;
		cfg_data <= cols;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cols_cfg = cols;
		cfg_index <= CFG_GRID_ROWS;
		cfg_data <= rows;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		rows_cfg = rows;
		cfg_valid <= 1'b0;
		grids_used++;
	endtask

	always @(posedge clk) begin
		move_t want;
		if (arst_n && out_valid && out_ready) begin
			action_seen[action]++;
			if (moves_due.size() == 0) begin
				$error("result arrived with no item outstanding");
				failures++;
			end else begin
				want = moves_due.pop_front();
				match_field("action", 16'(want.action), 16'(action));
				match_field("from_row", 16'(want.from_row), 16'(from_row));
				match_field("from_col", 16'(want.from_col), 16'(from_col));
				match_field("direction", 16'(want.direction), 16'(direction));
				match_field("to_row", 16'(want.to_row), 16'(to_row));
				match_field("to_col", 16'(want.to_col), 16'(to_col));
				match_field("cells_visited", 16'(want.cells_visited),
					    16'(cells_visited));
				match_field("done_res", 16'(want.done_res), 16'(done_res));
			end
		end
		out_ready <= no_gaps || $urandom_range(0, 99) >= 9;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no handshake for %0d cycles", QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int phase, gc, gr, burst;
		foreach (maze_cells[i])
			maze_cells[i] = '0;
		trail_depth = 0;
		visited_count = 0;
		carving = 1'b0;
		cols_cfg = GRID_RESET;
		rows_cfg = GRID_RESET;

		// A step before any start, then the smallest and the widest single-row grids.
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h0000, 1,
			mv(ACT_IDLE, 0, 0, DIR_NORTH, 0, 0, 0, 0))};
		drill = {drill, grid_row(0, 0)};
		drill = {drill, item_row(OP_START, 63, 63, 16'h0000, 1,
			mv(ACT_START, 0, 0, DIR_NORTH, 0, 0, 1, 1))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'hFFFF, 1,
			mv(ACT_IDLE, 0, 0, DIR_NORTH, 0, 0, 1, 1))};
		drill = {drill, grid_row(127, 1)};
		drill = {drill, item_row(OP_START, 63, 63, 16'h0000, 1,
			mv(ACT_START, 0, 63, DIR_NORTH, 0, 63, 1, 0))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'hFFFF, 1,
			mv(ACT_CARVE, 0, 63, DIR_WEST, 0, 62, 2, 0))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h5A5A, 0, '0)};
		// A full two-by-two maze, then a second start that carves north.
		drill = {drill, grid_row(2, 2)};
		drill = {drill, item_row(OP_START, 0, 0, 16'h0000, 1,
			mv(ACT_START, 0, 0, DIR_NORTH, 0, 0, 1, 0))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h0000, 1,
			mv(ACT_CARVE, 0, 0, DIR_EAST, 0, 1, 2, 0))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h0001, 1,
			mv(ACT_CARVE, 0, 1, DIR_SOUTH, 1, 1, 3, 0))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h0002, 1,
			mv(ACT_CARVE, 1, 1, DIR_WEST, 1, 0, 4, 1))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h0003, 1,
			mv(ACT_IDLE, 1, 0, DIR_NORTH, 1, 0, 4, 1))};
		drill = {drill, item_row(OP_START, 1, 1, 16'h0000, 1,
			mv(ACT_START, 1, 1, DIR_NORTH, 1, 1, 1, 0))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h0000, 1,
			mv(ACT_CARVE, 1, 1, DIR_NORTH, 0, 1, 2, 0))};
		// A dead end forces a backtrack before the row is finished.
		drill = {drill, grid_row(3, 1)};
		drill = {drill, item_row(OP_START, 0, 1, 16'h0000, 1,
			mv(ACT_START, 0, 1, DIR_NORTH, 0, 1, 1, 0))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h0000, 1,
			mv(ACT_CARVE, 0, 1, DIR_EAST, 0, 2, 2, 0))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h8000, 1,
			mv(ACT_BACK, 0, 2, DIR_NORTH, 0, 1, 2, 0))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h7FFF, 1,
			mv(ACT_CARVE, 0, 1, DIR_WEST, 0, 0, 3, 1))};
		// Resizing around a stranded start cell: finished, a pop to an empty
		// path, and a step on the empty path.
		drill = {drill, item_row(OP_START, 40, 63, 16'h0000, 1,
			mv(ACT_START, 0, 2, DIR_NORTH, 0, 2, 1, 0))};
		drill = {drill, grid_row(1, 1)};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h0000, 1,
			mv(ACT_IDLE, 0, 2, DIR_NORTH, 0, 2, 1, 1))};
		drill = {drill, grid_row(1, 2)};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h0000, 1,
			mv(ACT_BACK, 0, 2, DIR_NORTH, 0, 0, 1, 0))};
		drill = {drill, item_row(OP_STEP, 0, 0, 16'h0000, 1,
			mv(ACT_IDLE, 0, 0, DIR_NORTH, 0, 0, 1, 0))};

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drill[i]) begin
			if (drill[i].is_grid) begin
				drain();
				write_grid(drill[i].grid_cols, drill[i].grid_rows);
			end else begin
				offer_item(drill[i].item, drill[i].typed, drill[i].want);
			end
		end

		// Mostly small grids carved to completion; a phase without a start
		// resizes a maze that is still being carved.
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			drain();
			if (phase == 0) begin
				gc = 64;
				gr = 127;
			end else if ($urandom_range(0, 99) < 6) begin
				gc = $urandom_range(0, 127);
				gr = $urandom_range(0, 127);
			end else begin
				gc = $urandom_range(1, 8);
				gr = $urandom_range(1, 8);
			end
			write_grid(7'(gc), 7'(gr));
			burst = 2 * span(7'(gc), COLS_MAX) * span(7'(gr), ROWS_MAX)
				+ $urandom_range(0, 4);
			if (burst > 150)
				burst = (phase == 0) ? 300 : 150;
			if (phase == 0 || $urandom_range(0, 99) < 85)
				offer_random(1'b1);
			repeat (burst)
				offer_random($urandom_range(0, 99) < 3);
			phase++;
		end

		drain();
		repeat (30)
			@(posedge clk);
		$display("%0d items over %0d grid settings", items_sent, grids_used);
		$display("%0d starts, %0d carves, %0d backtracks, %0d finished or idle answers",
			action_seen[ACT_START], action_seen[ACT_CARVE], action_seen[ACT_BACK],
			action_seen[ACT_IDLE]);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
